// ----- rtl/core/tksi_pkg.sv -----
package tksi_pkg;

	localparam int DEPTH_DEF      = 10;
	localparam int SCORE_BITS_DEF = 24;
	localparam int TAG_BITS_DEF   = 24;
	localparam int RANK_BITS      = 4;
	localparam int COUNT_BITS     = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} cmd_t;

endpackage

// ----- rtl/core/top_k_score_table_insert_unit.sv -----
// Channel   Handshake            Ports
// offer     start & !busy        offer_score, offer_tag
// result    done (one cycle)     was_kept, kept_rank, filled_count, lowest_kept_score
//
// One offer goes through capture, compare in every cell, then shift-insert.
// The result beat shows in the cycle after the insert; busy is low by then,
// so the next offer can start while the result is shown.
// Reset empties the table at once; the receiver cannot stall the result beat.
module top_k_score_table_insert_unit
	import tksi_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [SCORE_BITS-1:0] offer_score,
	input  logic [TAG_BITS-1:0]   offer_tag,
	output logic                  done,
	output logic                  was_kept,
	output logic [RANK_BITS-1:0]  kept_rank,
	output logic [COUNT_BITS-1:0] filled_count,
	output logic [SCORE_BITS-1:0] lowest_kept_score
);

	cmd_t cmd;

	tksi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	tksi_dp #(
		.DEPTH      (DEPTH),
		.SCORE_BITS (SCORE_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.offer_score       (offer_score),
		.offer_tag         (offer_tag),
		.done              (done),
		.was_kept          (was_kept),
		.kept_rank         (kept_rank),
		.filled_count      (filled_count),
		.lowest_kept_score (lowest_kept_score)
	);

endmodule

// ----- rtl/core/tksi_ctrl.sv -----
module tksi_ctrl
	import tksi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CMP:  cmd.compare = 1'b1;
			ST_UPD:  cmd.update = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

// ----- rtl/core/tksi_dp.sv -----
module tksi_dp
	import tksi_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [SCORE_BITS-1:0] offer_score,
	input  logic [TAG_BITS-1:0]   offer_tag,
	output logic                  done,
	output logic                  was_kept,
	output logic [RANK_BITS-1:0]  kept_rank,
	output logic [COUNT_BITS-1:0] filled_count,
	output logic [SCORE_BITS-1:0] lowest_kept_score
);

	localparam int RANK_W = $clog2(DEPTH + 1);
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [SCORE_BITS-1:0] score_q [DEPTH];
	logic [TAG_BITS-1:0]   tag_q   [DEPTH];
	logic [SCORE_BITS-1:0] offer_score_q;
	logic [TAG_BITS-1:0]   offer_tag_q;
	logic [DEPTH-1:0]      gt_q;
	logic [DEPTH-1:0]      first;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_d;
	logic [SCORE_BITS-1:0] lowest_q;
	logic [SCORE_BITS-1:0] lowest_d;
	logic [RANK_W-1:0]     rank_d;
	logic [RANK_W-1:0]     rank_q;
	logic                  kept_q;
	logic                  done_q;
	logic                  kept;
	logic                  full;
	logic [31:0]           rank_wide;
	logic [31:0]           fill_wide;

	// capture offer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offer_score_q <= offer_score;
			offer_tag_q   <= offer_tag;
		end
	end

	// compare every cell against the offer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= '0;
		end else if (cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				gt_q[i] <= (score_q[i] < offer_score_q);
			end
		end
	end

	assign first[0] = gt_q[0];
	for (genvar i = 1; i < DEPTH; i++) begin : g_first
		assign first[i] = gt_q[i] & ~gt_q[i-1];
	end

	// shift-insert cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				score_q[i] <= '0;
				tag_q[i]   <= '0;
			end
		end else if (cmd.update) begin
			if (first[0]) begin
				score_q[0] <= offer_score_q;
				tag_q[0]   <= offer_tag_q;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (first[i]) begin
					score_q[i] <= offer_score_q;
					tag_q[i]   <= offer_tag_q;
				end else if (gt_q[i-1]) begin
					score_q[i] <= score_q[i-1];
					tag_q[i]   <= tag_q[i-1];
				end
			end
		end
	end

	assign kept = gt_q[DEPTH-1];
	assign full = (fill_q == FILL_W'(DEPTH));

	always_comb begin
		rank_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				rank_d = rank_d | RANK_W'(i + 1);
			end
		end
	end

	always_comb begin
		fill_d   = fill_q;
		lowest_d = lowest_q;
		if (kept) begin
			if (!full) begin
				fill_d = fill_q + 1'b1;
				if (fill_q == '0 || offer_score_q < lowest_q) begin
					lowest_d = offer_score_q;
				end
			end else if (first[DEPTH-1]) begin
				lowest_d = offer_score_q;
			end else begin
				lowest_d = score_q[DEPTH-2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			lowest_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				fill_q   <= fill_d;
				lowest_q <= lowest_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			kept_q <= kept;
			rank_q <= rank_d;
		end
	end

	assign rank_wide = 32'(rank_q);
	assign fill_wide = 32'(fill_q);

	assign done              = done_q;
	assign was_kept          = kept_q;
	assign kept_rank         = rank_wide[RANK_BITS-1:0];
	assign filled_count      = fill_wide[COUNT_BITS-1:0];
	assign lowest_kept_score = lowest_q;

endmodule

// ----- tb/top_k_table_checker.sv -----
`timescale 1ns / 1ps

module top_k_table_checker
	import tksi_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF,
	parameter int TAG_BITS   = TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [SCORE_BITS-1:0] offer_score,
	input  logic [TAG_BITS-1:0]   offer_tag,
	input  logic                  done,
	input  logic                  was_kept,
	input  logic [RANK_BITS-1:0]  kept_rank,
	input  logic [COUNT_BITS-1:0] filled_count,
	input  logic [SCORE_BITS-1:0] lowest_kept_score,
	output int                    outcomes_due,
	output int                    mismatch_count
);

	typedef struct {
		logic                  kept;
		logic [RANK_BITS-1:0]  rank;
		logic [COUNT_BITS-1:0] count;
		logic [SCORE_BITS-1:0] lowest;
	} insert_outcome_t;

	logic [SCORE_BITS-1:0] score_tab [DEPTH];
	logic [TAG_BITS-1:0]   tag_tab [DEPTH];
	insert_outcome_t       insert_outcomes [$];

	function automatic int count_filled();
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (score_tab[i] != '0)
				n++;
		end
		return n;
	endfunction

	task automatic rank_offer(input logic [SCORE_BITS-1:0] s, input logic [TAG_BITS-1:0] t,
			output insert_outcome_t r);
		int fill;
		int pos;
		bit kept;
		fill = count_filled();
		kept = 1'b0;
		pos = 0;
		if (s != '0) begin
			if (fill >= DEPTH) begin
				if (s > score_tab[DEPTH-1]) begin
					pos = DEPTH - 1;
					kept = 1'b1;
				end
			end else begin
				pos = fill;
				kept = 1'b1;
			end
		end
		if (kept) begin
			while (pos > 0 && score_tab[pos-1] < s) begin
				score_tab[pos] = score_tab[pos-1];
				tag_tab[pos] = tag_tab[pos-1];
				pos--;
			end
			score_tab[pos] = s;
			tag_tab[pos] = t;
			fill = count_filled();
		end
		r.kept = kept;
		r.rank = kept ? RANK_BITS'(pos + 1) : '0;
		r.count = COUNT_BITS'(fill);
		r.lowest = (fill > 0) ? score_tab[fill-1] : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		insert_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				score_tab[i] = '0;
				tag_tab[i] = '0;
			end
			insert_outcomes.delete();
			outcomes_due <= 0;
			mismatch_count <= 0;
		end else begin
			if (done) begin
				if (insert_outcomes.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result beat: kept=%0d rank=%0d count=%0d low=%h",
							was_kept, kept_rank, filled_count, lowest_kept_score);
				end else begin
					want = insert_outcomes.pop_front();
					if (was_kept !== want.kept || kept_rank !== want.rank ||
							filled_count !== want.count || lowest_kept_score !== want.lowest) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display({"mismatch: expected kept=%0d rank=%0d count=%0d low=%h, ",
								"got kept=%0d rank=%0d count=%0d low=%h"},
								want.kept, want.rank, want.count, want.lowest,
								was_kept, kept_rank, filled_count, lowest_kept_score);
					end
				end
			end
			if (start && !busy) begin
				rank_offer(offer_score, offer_tag, want);
				insert_outcomes.push_back(want);
			end
			outcomes_due <= insert_outcomes.size();
		end
	end

endmodule

// ----- tb/tb_top_k_score_table_insert_unit.sv -----
`timescale 1ns / 1ps

module tb_top_k_score_table_insert_unit;
	import tksi_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int SCORE_BITS  = SCORE_BITS_DEF;
	localparam int TAG_BITS    = TAG_BITS_DEF;
	localparam int OFFER_COUNT = 650;
	localparam int CALM_TAIL   = 100;
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [SCORE_BITS-1:0] offer_score;
	logic [TAG_BITS-1:0]   offer_tag;
	logic                  done;
	logic                  was_kept;
	logic [RANK_BITS-1:0]  kept_rank;
	logic [COUNT_BITS-1:0] filled_count;
	logic [SCORE_BITS-1:0] lowest_kept_score;

	int                    outcomes_due;
	int                    mismatch_count;
	int                    cycle_count;
	logic                  offer_taken;
	logic [SCORE_BITS-1:0] last_low;

	top_k_score_table_insert_unit #(
		.DEPTH(DEPTH),
		.SCORE_BITS(SCORE_BITS),
		.TAG_BITS(TAG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.offer_score(offer_score),
		.offer_tag(offer_tag),
		.done(done),
		.was_kept(was_kept),
		.kept_rank(kept_rank),
		.filled_count(filled_count),
		.lowest_kept_score(lowest_kept_score)
	);

	top_k_table_checker #(
		.DEPTH(DEPTH),
		.SCORE_BITS(SCORE_BITS),
		.TAG_BITS(TAG_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.offer_score(offer_score),
		.offer_tag(offer_tag),
		.done(done),
		.was_kept(was_kept),
		.kept_rank(kept_rank),
		.filled_count(filled_count),
		.lowest_kept_score(lowest_kept_score),
		.outcomes_due(outcomes_due),
		.mismatch_count(mismatch_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offer_taken <= 1'b0;
			last_low <= '0;
		end else begin
			offer_taken <= start && !busy;
			if (done)
				last_low <= lowest_kept_score;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("top_k_score_table_insert_unit regression: fail");
			$finish;
		end
	end

	// drive one offer beat and hold it until taken
	task automatic offer(input logic [SCORE_BITS-1:0] s, input logic [TAG_BITS-1:0] t);
		start <= 1'b1;
		offer_score <= s;
		offer_tag <= t;
		do @(negedge clk); while (!offer_taken);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outcomes_due != 0);
	endtask

	initial begin
		logic [SCORE_BITS-1:0] s;
		int pick;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		offer_score = '0;
		offer_tag = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer(24'h000000, 24'hFFFFFF);
		offer(24'h000001, 24'h000000);
		offer(24'hFFFFFF, 24'hFFFFFF);
		offer(24'h000001, 24'hAAAAAA);
		offer(24'h000000, 24'h555555);
		offer(24'd500, 24'h555555);
		offer(24'd500, 24'hAAAAAA);
		offer(24'd500, 24'h123456);
		offer(24'd300, 24'h000001);
		offer(24'd700, 24'h800000);
		offer(24'd100, 24'h7FFFFF);
		offer(24'd900, 24'h0F0F0F);
		// full table from here on
		offer(24'h000000, 24'hF0F0F0);
		offer(24'h000001, 24'h111111);
		offer(24'h000002, 24'h222222);
		offer(24'h000002, 24'h333333);
		offer(24'h000003, 24'h444444);
		offer(24'hFFFFFF, 24'h666666);
		offer(24'hFFFFFE, 24'h777777);
		offer(24'h800000, 24'h888888);
		offer(24'h7FFFFF, 24'h999999);
		drain();

		for (int i = 0; i < OFFER_COUNT; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				s = '0;
			else if (pick < 20)
				s = SCORE_BITS'($urandom);
			else if (pick < 35)
				s = SCORE_BITS'($urandom_range(1, 16));
			else if (pick < 55)
				s = last_low + SCORE_BITS'($urandom_range(0, 2)) - 1'b1;
			else
				s = SCORE_BITS'(i * 25000 + $urandom_range(0, 50000));
			offer(s, TAG_BITS'($urandom));
			if (i == OFFER_COUNT / 2)
				drain();
			else if (i < OFFER_COUNT - CALM_TAIL && $urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 9));
		end

		drain();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("top_k_score_table_insert_unit regression: pass");
		else
			$display("top_k_score_table_insert_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/tksi_pkg.sv
rtl/core/tksi_ctrl.sv
rtl/core/tksi_dp.sv
rtl/core/top_k_score_table_insert_unit.sv
tb/top_k_table_checker.sv
tb/tb_top_k_score_table_insert_unit.sv
